// ===== sv/pseudocolor_map_interpolator_macros.svh =====
// Assertion macros shared by the pseudocolor map interpolator modules.
`ifndef PSEUDOCOLOR_MAP_INTERPOLATOR_MACROS_SVH
`define PSEUDOCOLOR_MAP_INTERPOLATOR_MACROS_SVH
`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define PMI_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pmi check failed");
// Check that cons holds in the cycle after ante.
`define PMI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pmi check failed");
`else
`define PMI_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PMI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/pmi_pkg.sv =====
// Types, constants and colormap tables of the pseudocolor map interpolator.
package pmi_pkg;

	localparam int LEVEL_FRAC_BITS = 16;
	localparam int CHANNEL_BITS    = 8;
	localparam int LEVEL_W         = LEVEL_FRAC_BITS + 1;
	localparam int SEG_W           = 3;
	localparam int T_W             = LEVEL_FRAC_BITS + SEG_W;
	localparam int PROD_W          = CHANNEL_BITS + LEVEL_FRAC_BITS + 1;
	localparam int NUM_MAPS        = 5;
	localparam int MAX_POINTS      = 6;
	localparam int CH_MAX_I        = (1 << CHANNEL_BITS) - 1;

	typedef logic [CHANNEL_BITS-1:0]         chan_t;
	typedef logic [0:2][CHANNEL_BITS-1:0]    rgb_t;
	typedef logic [LEVEL_W-1:0]              level_t;
	typedef logic [SEG_W-1:0]                seg_t;
	typedef logic [T_W-1:0]                  scaled_t;
	typedef logic [PROD_W-1:0]               prod_t;

	typedef enum logic [2:0] {
		MAP_JET     = 3'd0,
		MAP_RGB     = 3'd1,
		MAP_HOT     = 3'd2,
		MAP_GREY    = 3'd3,
		MAP_GNUPLOT = 3'd4
	} map_t;

	localparam map_t MAP_LAST = MAP_GNUPLOT;

	localparam level_t LEVEL_ONE  = level_t'(1) << LEVEL_FRAC_BITS;
	localparam prod_t  ROUND_HALF = prod_t'(1) << (LEVEL_FRAC_BITS - 1);

	// Endpoints and fraction of one segment, handed to the blend stages.
	typedef struct packed {
		rgb_t   lo;
		rgb_t   hi;
		level_t frac;
	} seg_pair_t;

	// Scale a control point given in hundredths, rounding half up.
	function automatic chan_t scale_point(input int hundredths);
		return chan_t'((hundredths * CH_MAX_I * 2 + 100) / 200);
	endfunction

	localparam chan_t P0   = scale_point(0);
	localparam chan_t P25  = scale_point(25);
	localparam chan_t P50  = scale_point(50);
	localparam chan_t P60  = scale_point(60);
	localparam chan_t P75  = scale_point(75);
	localparam chan_t P90  = scale_point(90);
	localparam chan_t P100 = scale_point(100);

	// Control points per map, unused rows are black.
	localparam rgb_t POINTS [NUM_MAPS][MAX_POINTS] = '{
		'{ '{P0, P0, P100}, '{P0, P100, P100}, '{P100, P100, P0},
		   '{P100, P0, P0}, '{P100, P0, P100}, '{P0, P0, P100} },
		'{ '{P0, P0, P100}, '{P0, P100, P0}, '{P100, P0, P0},
		   '{P0, P0, P0}, '{P0, P0, P0}, '{P0, P0, P0} },
		'{ '{P0, P0, P0}, '{P100, P0, P0}, '{P100, P100, P0},
		   '{P100, P100, P100}, '{P0, P0, P0}, '{P0, P0, P0} },
		'{ '{P0, P0, P0}, '{P100, P100, P100}, '{P0, P0, P0},
		   '{P0, P0, P0}, '{P0, P0, P0}, '{P0, P0, P0} },
		'{ '{P0, P0, P0}, '{P50, P0, P100}, '{P60, P0, P60},
		   '{P75, P25, P0}, '{P90, P50, P0}, '{P100, P100, P0} }
	};

	// Number of segments of each map.
	function automatic seg_t seg_count(input map_t m);
		seg_t n;
		case (m)
			MAP_JET:     n = seg_t'(5);
			MAP_RGB:     n = seg_t'(2);
			MAP_HOT:     n = seg_t'(3);
			MAP_GREY:    n = seg_t'(1);
			MAP_GNUPLOT: n = seg_t'(5);
			default:     n = seg_t'(5);
		endcase
		return n;
	endfunction

endpackage

// ===== sv/pseudocolor_map_interpolator.sv =====
// Pseudocolor map interpolator top level: map register and the four-stage pipeline.
// Takes one level per clock while in_stall is low (Q1.16, values above 1.0
// saturate) and returns one 8-bit RGB pixel per level, interpolated along
// the colormap chosen by map_select (0 jet, 1 rgb, 2 hot, 3 grey, 4 gnuplot;
// other codes act as jet). A level passes four registered stages in order:
// stage 1 scales it by the segment count, stage 2 looks up the segment
// endpoints, stage 3 weights them and stage 4 rounds the sum. Every stage
// holds one beat, so a full pipeline sustains one pixel per clock while
// out_stall is low, and out_stall back-pressures only as far as the stages are full.
// Write map_select only while idle.
`include "pseudocolor_map_interpolator_macros.svh"
module pseudocolor_map_interpolator (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [pmi_pkg::LEVEL_W-1:0]           level,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [pmi_pkg::CHANNEL_BITS-1:0]      red,
	output logic [pmi_pkg::CHANNEL_BITS-1:0]      green,
	output logic [pmi_pkg::CHANNEL_BITS-1:0]      blue,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [2:0]                            map_select
);

	pmi_pkg::map_t      map_q;
	pmi_pkg::seg_pair_t seg_pair;
	pmi_pkg::rgb_t      pixel;
	logic               mid_valid;
	logic               mid_stall;

	// Register the map, folding unused codes onto jet.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q <= pmi_pkg::MAP_JET;
		end else if (cfg_valid && cfg_ready) begin
			if (map_select <= 3'(pmi_pkg::MAP_LAST)) begin
				map_q <= pmi_pkg::map_t'(map_select);
			end else begin
				map_q <= pmi_pkg::MAP_JET;
			end
		end
	end

	pmi_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.level     (level),
		.map_sel   (map_q),
		.out_valid (mid_valid),
		.out_stall (mid_stall),
		.seg_pair  (seg_pair)
	);

	pmi_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mid_valid),
		.in_stall  (mid_stall),
		.seg_pair  (seg_pair),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pixel     (pixel)
	);

	assign red   = pixel[0];
	assign green = pixel[1];
	assign blue  = pixel[2];

	`PMI_ASSERT_SAME(a_map_legal, clk, arst_n, 1'b1, map_q <= pmi_pkg::MAP_LAST)

endmodule

// ===== sv/pmi_front.sv =====
// Segment search and control point lookup: two pipeline stages.
`include "pseudocolor_map_interpolator_macros.svh"
module pmi_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  pmi_pkg::level_t   level,
	input  pmi_pkg::map_t     map_sel,
	output logic              out_valid,
	input  logic              out_stall,
	output pmi_pkg::seg_pair_t seg_pair
);

	logic               v_s1, v_s2;
	logic               en_s1, en_s2;
	pmi_pkg::scaled_t   t_s1;
	pmi_pkg::map_t      map_s1;
	pmi_pkg::seg_pair_t pair_s2;

	pmi_pkg::level_t    lvl_sat;
	pmi_pkg::seg_t      nm1_s1;
	pmi_pkg::seg_t      seg_raw;
	pmi_pkg::seg_t      seg_lo;
	pmi_pkg::seg_t      seg_hi;
	pmi_pkg::level_t    frac_c;

	// Advance a stage when it is empty or the next one takes its beat.
	assign en_s2    = !v_s2 || !out_stall;
	assign en_s1    = !v_s1 || en_s2;
	assign in_stall = !en_s1;

	// Saturate the level and scale it by the segment count.
	assign lvl_sat = level[pmi_pkg::LEVEL_FRAC_BITS] ? pmi_pkg::LEVEL_ONE : level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			t_s1   <= pmi_pkg::T_W'(lvl_sat) * pmi_pkg::T_W'(pmi_pkg::seg_count(map_sel));
			map_s1 <= map_sel;
		end
	end

	// Split into segment and fraction, clamp the top end.
	always_comb begin
		nm1_s1  = pmi_pkg::seg_count(map_s1);
		seg_raw = t_s1[pmi_pkg::LEVEL_FRAC_BITS +: pmi_pkg::SEG_W];
		seg_lo  = seg_raw;
		frac_c  = {1'b0, t_s1[pmi_pkg::LEVEL_FRAC_BITS-1:0]};
		if (seg_raw >= nm1_s1) begin
			seg_lo = nm1_s1 - pmi_pkg::seg_t'(1);
			frac_c = pmi_pkg::LEVEL_ONE;
		end
		seg_hi = seg_lo + pmi_pkg::seg_t'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			pair_s2.lo   <= pmi_pkg::POINTS[map_s1][seg_lo];
			pair_s2.hi   <= pmi_pkg::POINTS[map_s1][seg_hi];
			pair_s2.frac <= frac_c;
		end
	end

	assign out_valid = v_s2;
	assign seg_pair  = pair_s2;

	`PMI_ASSERT_SAME(a_frac_bound, clk, arst_n, v_s2, pair_s2.frac <= pmi_pkg::LEVEL_ONE)
	`PMI_ASSERT_SAME(a_stall_full, clk, arst_n, in_stall, v_s1 && v_s2)

endmodule

// ===== sv/pmi_blend.sv =====
// Linear blend of the two control points per channel: weight stage and sum stage.
`include "pseudocolor_map_interpolator_macros.svh"
module pmi_blend (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  pmi_pkg::seg_pair_t seg_pair,
	output logic               out_valid,
	input  logic               out_stall,
	output pmi_pkg::rgb_t      pixel
);

	logic                 v_s3, v_s4;
	logic                 en_s3, en_s4;
	pmi_pkg::prod_t [0:2] wlo_s3;
	pmi_pkg::prod_t [0:2] whi_s3;
	pmi_pkg::rgb_t        pixel_s4;
	pmi_pkg::prod_t [0:2] sum_c;
	pmi_pkg::level_t      inv_frac;

	// Advance a stage when it is empty or the next one takes its beat.
	assign en_s4    = !v_s4 || !out_stall;
	assign en_s3    = !v_s3 || en_s4;
	assign in_stall = !en_s3;

	assign inv_frac = pmi_pkg::LEVEL_ONE - seg_pair.frac;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s3) begin
				v_s3 <= in_valid;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// Weight both endpoints of each channel.
	always_ff @(posedge clk) begin
		if (en_s3 && in_valid) begin
			for (int c = 0; c < 3; c++) begin
				wlo_s3[c] <= pmi_pkg::PROD_W'(seg_pair.lo[c]) * pmi_pkg::PROD_W'(inv_frac);
				whi_s3[c] <= pmi_pkg::PROD_W'(seg_pair.hi[c]) * pmi_pkg::PROD_W'(seg_pair.frac);
			end
		end
	end

	// Add, round half up and drop the fraction.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum_c[c] = wlo_s3[c] + whi_s3[c] + pmi_pkg::ROUND_HALF;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			for (int c = 0; c < 3; c++) begin
				pixel_s4[c] <= sum_c[c][pmi_pkg::LEVEL_FRAC_BITS +: pmi_pkg::CHANNEL_BITS];
			end
		end
	end

	assign out_valid = v_s4;
	assign pixel     = pixel_s4;

	`PMI_ASSERT_SAME(a_blend_stall_full, clk, arst_n, in_stall, v_s3 && v_s4)
	`PMI_ASSERT_NEXT(a_blend_moves, clk, arst_n, v_s3 && en_s4, v_s4)

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the pseudocolor map interpolator.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HALF_PERIOD   = 5;
	localparam int STALL_LIMIT   = 2000;
	localparam int DRAIN_CYCLES  = 8;
	localparam int LONG_HOLD     = 60;
	localparam int PHASE_ITEMS   = 100;
	localparam int NUM_PHASES    = 8;
	localparam longint unsigned UNIT_LEVEL = longint'(1) << pmi_pkg::LEVEL_FRAC_BITS;
	localparam pmi_pkg::level_t LEVEL_MAX = '1;

	// Selector codes with no map of their own; the block treats them as jet.
	localparam logic [2:0] SEL_UNUSED_5 = 3'd5;
	localparam logic [2:0] SEL_UNUSED_6 = 3'd6;
	localparam logic [2:0] SEL_UNUSED_7 = 3'd7;

	typedef struct packed {
		pmi_pkg::chan_t red;
		pmi_pkg::chan_t green;
		pmi_pkg::chan_t blue;
	} pixel_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            in_valid = 1'b0;
	logic            in_stall;
	pmi_pkg::level_t level = '0;
	logic            out_valid;
	logic            out_stall = 1'b0;
	pmi_pkg::chan_t  red, green, blue;
	logic            cfg_valid = 1'b0;
	logic            cfg_ready;
	logic [2:0]      map_select = '0;

	pmi_pkg::level_t level_queue[$];
	pixel_t          expected_pixels[$];
	logic [2:0]      active_map = '0;
	logic            in_taken = 1'b0;
	int              send_idle_pct = 0;
	int              recv_idle_pct = 0;
	int              hold_requests = 0;
	int              holds_served = 0;
	int              hold_left = 0;
	int              quiet_cycles = 0;
	int              fail_count = 0;

	pseudocolor_map_interpolator dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.level      (level),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.map_select (map_select)
	);

	always #HALF_PERIOD clk = ~clk;

	// Resolve the selector to a map; spare codes fall back to jet.
	function automatic pmi_pkg::map_t resolve_map(input logic [2:0] sel);
		return (sel <= pmi_pkg::MAP_LAST) ? pmi_pkg::map_t'(sel) : pmi_pkg::MAP_JET;
	endfunction

	function automatic int unsigned knot_count(input pmi_pkg::map_t m);
		case (m)
			pmi_pkg::MAP_RGB:  return 3;
			pmi_pkg::MAP_HOT:  return 4;
			pmi_pkg::MAP_GREY: return 2;
			default:           return 6;
		endcase
	endfunction

	// Control point channel in hundredths of full intensity.
	function automatic int unsigned knot_pct(input pmi_pkg::map_t m, input int unsigned k,
			input int unsigned c);
		logic [0:17][7:0] pts;
		case (m)
			pmi_pkg::MAP_RGB: pts = {8'd0, 8'd0, 8'd100, 8'd0, 8'd100, 8'd0, 8'd100, 8'd0,
				8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
			pmi_pkg::MAP_HOT: pts = {8'd0, 8'd0, 8'd0, 8'd100, 8'd0, 8'd0, 8'd100, 8'd100,
				8'd0, 8'd100, 8'd100, 8'd100, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
			pmi_pkg::MAP_GREY: pts = {8'd0, 8'd0, 8'd0, 8'd100, 8'd100, 8'd100, 8'd0, 8'd0,
				8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
			pmi_pkg::MAP_GNUPLOT: pts = {8'd0, 8'd0, 8'd0, 8'd50, 8'd0, 8'd100, 8'd60, 8'd0,
				8'd60, 8'd75, 8'd25, 8'd0, 8'd90, 8'd50, 8'd0, 8'd100, 8'd100, 8'd0};
			default: pts = {8'd0, 8'd0, 8'd100, 8'd0, 8'd100, 8'd100, 8'd100, 8'd100, 8'd0,
				8'd100, 8'd0, 8'd0, 8'd100, 8'd0, 8'd100, 8'd0, 8'd0, 8'd100};
		endcase
		return 32'(pts[k*3 + c]);
	endfunction

	// Blend one channel between the knots at seg and seg+1, rounding half up.
	function automatic pmi_pkg::chan_t blend_channel(input pmi_pkg::map_t m,
			input int unsigned seg, input longint unsigned frac, input int unsigned c);
		longint unsigned a, b, v;
		a = (longint'(knot_pct(m, seg, c)) * pmi_pkg::CH_MAX_I * 2 + 100) / 200;
		b = (longint'(knot_pct(m, seg + 1, c)) * pmi_pkg::CH_MAX_I * 2 + 100) / 200;
		v = (a * (UNIT_LEVEL - frac) + b * frac + (UNIT_LEVEL >> 1))
			>> pmi_pkg::LEVEL_FRAC_BITS;
		return pmi_pkg::chan_t'(v);
	endfunction

	function automatic pixel_t predict_pixel(input pmi_pkg::level_t lvl,
			input logic [2:0] sel);
		pmi_pkg::map_t m;
		int unsigned npts, seg;
		longint unsigned sat, t, frac;
		pixel_t px;
		m = resolve_map(sel);
		npts = knot_count(m);
		// Saturate above one, then split into segment and fraction.
		sat = (lvl > UNIT_LEVEL) ? UNIT_LEVEL : longint'(lvl);
		t = sat * (npts - 1);
		seg = int'(t >> pmi_pkg::LEVEL_FRAC_BITS);
		frac = t & (UNIT_LEVEL - 1);
		if (seg >= npts - 1) begin
			seg = npts - 2;
			frac = UNIT_LEVEL;
		end
		px.red = blend_channel(m, seg, frac, 0);
		px.green = blend_channel(m, seg, frac, 1);
		px.blue = blend_channel(m, seg, frac, 2);
		return px;
	endfunction

	// Pick a level: extremes, segment edges, in-range and saturating values.
	function automatic pmi_pkg::level_t random_level(input logic [2:0] sel);
		int unsigned pick, npts, k;
		longint signed edge_lvl;
		pick = $urandom_range(99);
		npts = knot_count(resolve_map(sel));
		if (pick < 15) begin
			case ($urandom_range(4))
				0: return '0;
				1: return pmi_pkg::level_t'(UNIT_LEVEL - 1);
				2: return pmi_pkg::level_t'(UNIT_LEVEL);
				3: return pmi_pkg::level_t'(UNIT_LEVEL + 1);
				default: return LEVEL_MAX;
			endcase
		end else if (pick < 40) begin
			k = $urandom_range(npts - 1, 1);
			edge_lvl = longint'((k * UNIT_LEVEL) / (npts - 1)) + $urandom_range(4) - 2;
			if (edge_lvl < 0)
				edge_lvl = 0;
			return pmi_pkg::level_t'(edge_lvl);
		end else if (pick < 85) begin
			return pmi_pkg::level_t'($urandom_range(UNIT_LEVEL));
		end
		return pmi_pkg::level_t'($urandom_range(LEVEL_MAX, UNIT_LEVEL + 1));
	endfunction

	// Sample both channels at the edge: predict on input beats, check output beats.
	always @(posedge clk) begin
		pixel_t exp_px;
		in_taken = 1'b0;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				in_taken = 1'b1;
				expected_pixels.push_back(predict_pixel(level, active_map));
			end
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					$error("unexpected pixel %0d/%0d/%0d", red, green, blue);
					fail_count++;
				end else begin
					exp_px = expected_pixels.pop_front();
					if (red !== exp_px.red) begin
						$error("red: expected %0d, got %0d", exp_px.red, red);
						fail_count++;
					end
					if (green !== exp_px.green) begin
						$error("green: expected %0d, got %0d", exp_px.green, green);
						fail_count++;
					end
					if (blue !== exp_px.blue) begin
						$error("blue: expected %0d, got %0d", exp_px.blue, blue);
						fail_count++;
					end
				end
			end
		end
		// Watchdog: end the run when no channel moves for too long.
		if (in_taken || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Level driver: hold the beat until taken, then advance or idle.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (level_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				level <= level_queue.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Pixel receiver: random stalls plus long hold-offs on request.
	always @(negedge clk) begin
		if (hold_left == 0 && holds_served < hold_requests) begin
			holds_served++;
			hold_left = LONG_HOLD;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	task automatic wait_drained();
		bit drained;
		drained = 1'b0;
		while (!drained) begin
			@(negedge clk);
			#1;
			drained = (level_queue.size() == 0) && !in_valid && (expected_pixels.size() == 0);
		end
	endtask

	task automatic write_map(input logic [2:0] sel);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b1;
		map_select = sel;
		do
			@(posedge clk);
		while (!cfg_ready);
		active_map = sel;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	initial begin
		logic [2:0] phase_maps [NUM_PHASES];
		pmi_pkg::level_t directed [$];
		phase_maps = '{pmi_pkg::MAP_GNUPLOT, SEL_UNUSED_7, pmi_pkg::MAP_RGB,
			pmi_pkg::MAP_HOT, SEL_UNUSED_5, pmi_pkg::MAP_GREY, SEL_UNUSED_6,
			pmi_pkg::MAP_JET};
		directed = '{'0, 17'd1, 17'd2, 17'd13107, 17'd13108, 17'd21845, 17'd26214,
			17'd26215, 17'd32768, 17'd39321, 17'd39322, 17'd43690, 17'd52428, 17'd52429,
			17'd65535, 17'd65536, 17'd65537, 17'd98304, 17'h0AAAA, 17'h15555, LEVEL_MAX};

		// Hold reset, then release it at a falling clock edge.
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed levels on the reset map.
		send_idle_pct = 6;
		recv_idle_pct = 78;
		foreach (directed[i])
			level_queue.push_back(directed[i]);

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_map(phase_maps[p]);
			if (p < 3) begin
				send_idle_pct = 6;
				recv_idle_pct = 78;
			end else if (p < 6) begin
				send_idle_pct = 78;
				recv_idle_pct = 6;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			// Back up the pipeline while the sender keeps offering beats.
			if (p == 1 || p == 6)
				hold_requests++;
			for (int i = 0; i < PHASE_ITEMS / 2; i++)
				level_queue.push_back(random_level(phase_maps[p]));
			// Pause the sender until every pixel is back.
			wait_drained();
			for (int i = 0; i < PHASE_ITEMS / 2; i++)
				level_queue.push_back(random_level(phase_maps[p]));
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
